>>> hw/rtl/fqd_pkg.sv
package fqd_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ENT_W       = IDX_W + VALUE_WIDTH;
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELD_W = CNT_W + VALUE_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_DEL = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ENQ_WB,
        ST_DEQ_WB,
        ST_DEL_CHK,
        ST_DEL_M1,
        ST_DEL_M2,
        ST_RESP
    } t_state;

    // entry store: {prev link, value}
    typedef struct packed {
        logic               we;
        t_idx               waddr;
        logic [ENT_W-1:0]   wdata;
        t_idx               raddr;
    } t_ent_req;

    // next-link store
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_idx wdata;
        t_idx raddr;
    } t_lnk_req;

endpackage

>>> hw/rtl/fqd_ram.sv
module fqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/fqd_links.sv
module fqd_links (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fqd_pkg::t_lnk_req i_req,
    output fqd_pkg::t_idx     o_next
);
    import fqd_pkg::*;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    t_idx             r_raddr;
    logic             r_rvld;
    t_idx             ram_q;
    t_idx             chain_q;

    fqd_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_vld = r_vld;
        if (i_req.we) begin
            n_vld[i_req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
        r_raddr <= i_req.raddr;
        r_rvld  <= r_vld[i_req.raddr];
    end

    // unwritten slots read as the power-up free chain
    assign chain_q = (r_raddr == t_idx'(DEPTH - 1)) ? '0 : r_raddr + t_idx'(1);
    assign o_next  = r_rvld ? ram_q : chain_q;

endmodule

>>> hw/rtl/fqd_ctrl.sv
module fqd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  fqd_pkg::t_val     i_value,
    input  logic [1:0]        i_cmd,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic              o_status,
    output fqd_pkg::t_val     o_value,
    output fqd_pkg::t_cnt     o_count,
    output fqd_pkg::t_ent_req o_ent_req,
    input  logic [fqd_pkg::ENT_W-1:0] i_ent_q,
    output fqd_pkg::t_lnk_req o_lnk_req,
    input  fqd_pkg::t_idx     i_lnk_q
);
    import fqd_pkg::*;

    t_state r_state, n_state;
    logic   [1:0] r_cmd;
    t_val   r_val;
    t_idx   r_front, n_front;
    t_idx   r_rear, n_rear;
    t_idx   r_free, n_free;
    t_cnt   r_count, n_count;
    t_idx   r_cur, n_cur;
    t_cnt   r_i, n_i;
    t_idx   r_prev, n_prev;
    t_idx   r_next, n_next;
    logic   r_status, n_status;
    t_val   r_got, n_got;
    logic   r_ovalid, n_ovalid;
    logic   r_ostatus, n_ostatus;
    t_val   r_ogot, n_ogot;
    t_cnt   r_ocount, n_ocount;

    t_val   ent_val;
    t_idx   ent_prev;
    logic   accept;

    assign ent_val  = i_ent_q[VALUE_WIDTH-1:0];
    assign ent_prev = i_ent_q[ENT_W-1:VALUE_WIDTH];
    assign accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_rear    = r_rear;
        n_free    = r_free;
        n_count   = r_count;
        n_cur     = r_cur;
        n_i       = r_i;
        n_prev    = r_prev;
        n_next    = r_next;
        n_status  = r_status;
        n_got     = r_got;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_ostatus = r_ostatus;
        n_ogot    = r_ogot;
        n_ocount  = r_ocount;
        o_s_tready = (r_state == ST_IDLE);
        o_ent_req = '{we: 1'b0, waddr: r_cur, wdata: {r_prev, r_val}, raddr: r_cur};
        o_lnk_req = '{we: 1'b0, waddr: r_cur, wdata: r_free, raddr: r_cur};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_got    = '0;
                n_status = 1'b1;
                n_state  = ST_RESP;
                case (r_cmd)
                    CMD_ENQ: begin
                        if (r_val != '0 && r_count != t_cnt'(DEPTH)) begin
                            o_lnk_req.raddr = r_free;
                            o_ent_req.we    = 1'b1;
                            o_ent_req.waddr = r_free;
                            if (r_count == '0) begin
                                o_ent_req.wdata = {r_free, r_val};
                                n_front = r_free;
                            end else begin
                                o_ent_req.wdata = {r_rear, r_val};
                                o_lnk_req.we    = 1'b1;
                                o_lnk_req.waddr = r_rear;
                                o_lnk_req.wdata = r_free;
                            end
                            n_rear   = r_free;
                            n_count  = r_count + t_cnt'(1);
                            n_status = 1'b0;
                            n_state  = ST_ENQ_WB;
                        end
                    end
                    CMD_DEQ: begin
                        if (r_count != '0) begin
                            o_ent_req.raddr = r_front;
                            o_lnk_req.raddr = r_front;
                            n_status = 1'b0;
                            n_state  = ST_DEQ_WB;
                        end
                    end
                    CMD_DEL: begin
                        if (r_val != '0 && r_count != '0) begin
                            o_ent_req.raddr = r_front;
                            o_lnk_req.raddr = r_front;
                            n_cur   = r_front;
                            n_i     = '0;
                            n_state = ST_DEL_CHK;
                        end
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_ENQ_WB: begin
                n_free  = i_lnk_q;
                n_state = ST_RESP;
            end
            ST_DEQ_WB: begin
                n_got = ent_val;
                if (r_count > t_cnt'(1)) begin
                    n_front = i_lnk_q;
                end
                n_count         = r_count - t_cnt'(1);
                o_lnk_req.we    = 1'b1;
                o_lnk_req.waddr = r_front;
                o_lnk_req.wdata = r_free;
                n_free          = r_front;
                n_state         = ST_RESP;
            end
            ST_DEL_CHK: begin
                if (ent_val == r_val) begin
                    n_status = 1'b0;
                    if (r_count == t_cnt'(1) || r_cur == r_front || r_cur == r_rear) begin
                        if (r_count > t_cnt'(1)) begin
                            if (r_cur == r_front) begin
                                n_front = i_lnk_q;
                            end else begin
                                n_rear = ent_prev;
                            end
                        end
                        o_lnk_req.we = 1'b1;
                        n_free       = r_cur;
                        n_count      = r_count - t_cnt'(1);
                        n_state      = ST_RESP;
                    end else begin
                        n_prev  = ent_prev;
                        n_next  = i_lnk_q;
                        n_state = ST_DEL_M1;
                    end
                end else if (r_i == r_count - t_cnt'(1)) begin
                    n_status = 1'b1;
                    n_state  = ST_RESP;
                end else begin
                    // follow the chain; issue the next read right away
                    o_ent_req.raddr = i_lnk_q;
                    o_lnk_req.raddr = i_lnk_q;
                    n_cur = i_lnk_q;
                    n_i   = r_i + t_cnt'(1);
                end
            end
            ST_DEL_M1: begin
                o_lnk_req.we    = 1'b1;
                o_lnk_req.waddr = r_prev;
                o_lnk_req.wdata = r_next;
                o_ent_req.raddr = r_next;
                n_state         = ST_DEL_M2;
            end
            ST_DEL_M2: begin
                o_ent_req.we    = 1'b1;
                o_ent_req.waddr = r_next;
                o_ent_req.wdata = {r_prev, ent_val};
                o_lnk_req.we    = 1'b1;
                n_free          = r_cur;
                n_count         = r_count - t_cnt'(1);
                n_state         = ST_RESP;
            end
            ST_RESP: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ogot    = r_got;
                    n_ocount  = r_count;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_front  <= '0;
            r_rear   <= '0;
            r_free   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_free   <= n_free;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        if (accept) begin
            r_cmd <= i_cmd;
            r_val <= i_value;
        end
        r_cur     <= n_cur;
        r_i       <= n_i;
        r_prev    <= n_prev;
        r_next    <= n_next;
        r_status  <= n_status;
        r_got     <= n_got;
        r_ostatus <= n_ostatus;
        r_ogot    <= n_ogot;
        r_ocount  <= n_ocount;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_status   = r_ostatus;
    assign o_value    = r_ogot;
    assign o_count    = r_ocount;

endmodule

>>> hw/rtl/fifo_queue_with_delete.sv
// Channel   Dir  tdata (low bit up)                    tuser
// s         in   value[31:0]                           cmd[1:0] (0 enq, 1 deq, 2 delete)
// m         out  value_out[31:0], count[36:32], pad    status[0] (1 error)
//
// One request at a time. Requests rejected at decode go straight to the response state.
// Enqueue and dequeue add a write-back state for the registered read of the link store.
// Delete walks the list from the front, one entry per cycle through the link store
// read port; a miss walks all entries; a middle entry adds states DEL_M1 and DEL_M2.
// Reset is synchronous; the free chain comes from per-slot valid bits, no clear pass.
// A held result does not block accepting the next request; only its RESP state waits.
module fifo_queue_with_delete (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [fqd_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // value
    input  logic [1:0]                       i_s_tuser,  // cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [fqd_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // value_out, count, zero pad
    output logic [0:0]                       o_m_tuser   // status
);
    import fqd_pkg::*;

    t_ent_req         ent_req;
    t_lnk_req         lnk_req;
    logic [ENT_W-1:0] ent_q;
    t_idx             lnk_q;
    logic             status;
    t_val             value_out;
    t_cnt             count;

    fqd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_req.we),
        .i_waddr (ent_req.waddr),
        .i_wdata (ent_req.wdata),
        .i_raddr (ent_req.raddr),
        .o_rdata (ent_q)
    );

    fqd_links u_links (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lnk_req),
        .o_next  (lnk_q)
    );

    fqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_value    (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_cmd      (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_status   (status),
        .o_value    (value_out),
        .o_count    (count),
        .o_ent_req  (ent_req),
        .i_ent_q    (ent_q),
        .o_lnk_req  (lnk_req),
        .i_lnk_q    (lnk_q)
    );

    assign o_m_tdata = OUT_TDATA_W'({count, value_out});
    assign o_m_tuser = status;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import fqd_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_WAIT  = 64;

    typedef struct {
        logic [1:0] cmd;
        t_val       val;
    } t_qreq;

    typedef struct {
        logic status;
        t_val value_out;
        t_cnt count;
    } t_qresp;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata  = '0;  // value
    logic [1:0]              i_s_tuser  = '0;  // cmd
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;        // value_out, count, zero pad
    logic [0:0]              o_m_tuser;        // status

    t_qreq  req_q[$];
    t_qresp due_resp_q[$];
    t_val   held_vals[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_phase = 1'b0;
    bit hold_done      = 1'b0;
    int hold_left      = 0;
    int errors         = 0;

    fifo_queue_with_delete DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(64'd6_000_000);
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // shadow of the queue contents; one response per request
    function automatic void apply_queue_cmd(input logic [1:0] cmd, input t_val v);
        t_qresp r;
        bit     ok;
        int     hit;
        ok  = 1'b0;
        r.value_out = '0;
        if (cmd == CMD_ENQ) begin
            if (v != 0 && held_vals.size() < DEPTH) begin
                held_vals.push_back(v);
                ok = 1'b1;
            end
        end else if (cmd == CMD_DEQ) begin
            if (held_vals.size() != 0) begin
                r.value_out = held_vals.pop_front();
                ok = 1'b1;
            end
        end else if (cmd == CMD_DEL) begin
            hit = -1;
            if (v != 0) begin
                for (int i = 0; i < held_vals.size(); i++) begin
                    if (hit < 0 && held_vals[i] == v) hit = i;
                end
            end
            if (hit >= 0) begin
                held_vals.delete(hit);
                ok = 1'b1;
            end
        end
        r.status = !ok;
        r.count  = t_cnt'(held_vals.size());
        due_resp_q.push_back(r);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= req_q[0].cmd;
                i_s_tdata  <= req_q[0].val;
                void'(req_q.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            apply_queue_cmd(i_s_tuser, i_s_tdata[VALUE_WIDTH-1:0]);
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (pressure_phase && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // response monitor
    always @(posedge i_clk) begin
        t_qresp e;
        t_cnt   got_cnt;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_cnt = o_m_tdata[VALUE_WIDTH +: CNT_W];
            if (due_resp_q.size() == 0) begin
                flag($sformatf("unexpected response status=%0d value=%h count=%0d",
                               o_m_tuser[0], o_m_tdata[VALUE_WIDTH-1:0], got_cnt));
            end else begin
                e = due_resp_q.pop_front();
                if (o_m_tuser[0] !== e.status)
                    flag($sformatf("status %0d, want %0d", o_m_tuser[0], e.status));
                if (o_m_tdata[VALUE_WIDTH-1:0] !== e.value_out)
                    flag($sformatf("value_out %h, want %h",
                                   o_m_tdata[VALUE_WIDTH-1:0], e.value_out));
                if (got_cnt !== e.count)
                    flag($sformatf("count %0d, want %0d", got_cnt, e.count));
            end
        end
    end

    task automatic add_req(input logic [1:0] cmd, input t_val v);
        t_qreq q;
        q.cmd = cmd;
        q.val = v;
        req_q.push_back(q);
    endtask

    // fill / drain bursts so the queue swings between empty and full
    task automatic add_random(input int n);
        int         r;
        bit         fill;
        logic [1:0] c;
        t_val       v;
        fill = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i % 20 == 0) fill = 1'($urandom_range(1));
            r = $urandom_range(99);
            v = ($urandom_range(3) == 0) ? t_val'($urandom) : t_val'($urandom_range(20, 1));
            if (r < 2) begin
                c = CMD_UNKNOWN;
            end else if (r < 5) begin
                c = $urandom_range(1) ? CMD_ENQ : CMD_DEL;
                v = '0;
            end else if (r < (fill ? 70 : 35)) begin
                c = CMD_ENQ;
            end else if (r < (fill ? 82 : 70)) begin
                c = CMD_DEQ;
            end else begin
                c = CMD_DEL;
            end
            add_req(c, v);
        end
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || i_s_tvalid || due_resp_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: error cases on empty, fill to full, removals at each position
        add_req(CMD_DEQ, 32'h0000_0007);
        add_req(CMD_DEL, 32'h0000_0005);
        add_req(CMD_ENQ, 32'h0000_0000);
        add_req(CMD_UNKNOWN, 32'h1234_5678);
        add_req(CMD_ENQ, 32'hFFFF_FFFF);
        add_req(CMD_ENQ, 32'h8000_0000);
        add_req(CMD_ENQ, 32'h0000_0001);
        add_req(CMD_ENQ, 32'hA5A5_A5A5);
        add_req(CMD_ENQ, 32'h5A5A_5A5A);
        for (int i = 0; i < DEPTH - 5; i++)
            add_req(CMD_ENQ, t_val'(i + 2));
        add_req(CMD_ENQ, 32'h0000_0099);
        add_req(CMD_DEL, 32'h0000_0000);
        add_req(CMD_DEL, 32'hFFFF_FFFF);
        add_req(CMD_DEL, t_val'(DEPTH - 4));
        add_req(CMD_DEL, 32'hA5A5_A5A5);
        add_req(CMD_DEL, 32'hDEAD_BEEF);
        add_req(CMD_DEQ, 32'hFFFF_FFFF);
        wait_drained();

        add_random(125);
        wait_drained();

        send_idle_pct = 80;
        add_random(125);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 80;
        add_random(125);
        wait_drained();

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        add_random(125);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_phase = 1'b1;
        add_random(30);
        wait_drained();

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
